// ===== design/source_tokenizer_assert.svh =====
// assertion macros shared by the tokenizer modules
`ifndef SOURCE_TOKENIZER_ASSERT_SVH
`define SOURCE_TOKENIZER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define STOK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence in the cycle after the antecedent
`define STOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stok_pkg.sv =====
// types and constants shared by the tokenizer modules
package stok_pkg;

    localparam int MAX_RESULTS = 4;
    localparam int RES_IDX_W   = 2;
    localparam int RES_COUNT_W = 3;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       byte_present;
        logic       end_of_source;
    } source_item_t;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [15:0] token_line;
        logic [15:0] token_column;
        logic [7:0]  value_byte;
        logic        value_valid;
        logic        token_done;
        logic [15:0] token_length;
        logic [2:0]  error_code;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [RES_COUNT_W-1:0]          count;
        result_t [MAX_RESULTS-1:0]       recs;
    } bundle_t;

endpackage

// ===== design/source_tokenizer.sv =====
// source tokenizer top level: lexer front, bundle queue and result back
//
//   channel   handshake           payload
//   source    push / full         source_item_t: byte, present flag, end flag
//   token     empty / pop         result_t: one value or token record
//   cfg       cfg_valid/cfg_ready cfg_data: start_line
//
// the front takes one source item per cycle while full is low and writes all of its results
// (up to four) into the bundle queue as one entry in the same cycle
// the back gives one result per cycle while pop is high, so an item with k results
// holds the result side for k pops; full rises when QUEUE_DEPTH bundles wait
// reset: line count 2, column 1; a cfg transfer reloads the line count
// after an error record, items are still taken but give no results until reset
module source_tokenizer #(
    parameter int POSITION_WIDTH = 16,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  stok_pkg::source_item_t source,
    output logic                   empty,
    input  logic                   pop,
    output stok_pkg::result_t      token,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);

    logic              wr_en;
    logic              rd_en;
    logic              nonempty;
    stok_pkg::bundle_t wr_bundle;
    stok_pkg::bundle_t rd_bundle;

    assign cfg_ready = 1'b1;

    stok_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .source    (source),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .wr_en     (wr_en),
        .bundle    (wr_bundle)
    );

    stok_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_bundle),
        .full     (full),
        .rd_en    (rd_en),
        .rd_data  (rd_bundle),
        .nonempty (nonempty)
    );

    stok_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .nonempty (nonempty),
        .rd_data  (rd_bundle),
        .rd_en    (rd_en),
        .pop      (pop),
        .empty    (empty),
        .token    (token)
    );

endmodule

// ===== design/stok_front.sv =====
// lexer front: classifies each source byte and builds the bundle of results it causes
`include "source_tokenizer_assert.svh"

module stok_front #(
    parameter int POSITION_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  stok_pkg::source_item_t source,
    input  logic                  full,
    input  logic                  cfg_valid,
    input  logic [15:0]           cfg_data,
    output logic                  wr_en,
    output stok_pkg::bundle_t     bundle
);

    localparam int PW = POSITION_WIDTH;
    localparam int XW = (PW > 16) ? PW : 16;

    localparam logic [3:0] MODE_IDLE    = 4'd0;
    localparam logic [3:0] MODE_IDENT   = 4'd1;
    localparam logic [3:0] MODE_NUMBER  = 4'd2;
    localparam logic [3:0] MODE_STRING  = 4'd3;
    localparam logic [3:0] MODE_COMMENT = 4'd4;
    localparam logic [3:0] MODE_SLASH   = 4'd5;
    localparam logic [3:0] MODE_EQ      = 4'd6;
    localparam logic [3:0] MODE_LT      = 4'd7;
    localparam logic [3:0] MODE_GT      = 4'd8;
    localparam logic [3:0] MODE_BANG    = 4'd9;
    localparam logic [3:0] MODE_PLUS    = 4'd10;
    localparam logic [3:0] MODE_MINUS   = 4'd11;
    localparam logic [3:0] MODE_STAR    = 4'd12;
    localparam logic [3:0] MODE_HALT    = 4'd13;

    localparam logic [4:0] KIND_EOF    = 5'd0;
    localparam logic [4:0] KIND_NUM    = 5'd1;
    localparam logic [4:0] KIND_STR    = 5'd2;
    localparam logic [4:0] KIND_ID     = 5'd3;
    localparam logic [4:0] KIND_LPAREN = 5'd4;
    localparam logic [4:0] KIND_RPAREN = 5'd5;
    localparam logic [4:0] KIND_LBRACK = 5'd6;
    localparam logic [4:0] KIND_RBRACK = 5'd7;
    localparam logic [4:0] KIND_LBRACE = 5'd8;
    localparam logic [4:0] KIND_RBRACE = 5'd9;
    localparam logic [4:0] KIND_SEMI   = 5'd10;
    localparam logic [4:0] KIND_COMMA  = 5'd11;
    localparam logic [4:0] KIND_COLON  = 5'd12;
    localparam logic [4:0] KIND_EQEQ   = 5'd13;
    localparam logic [4:0] KIND_LE     = 5'd14;
    localparam logic [4:0] KIND_LT     = 5'd15;
    localparam logic [4:0] KIND_GE     = 5'd16;
    localparam logic [4:0] KIND_GT     = 5'd17;
    localparam logic [4:0] KIND_NE     = 5'd18;
    localparam logic [4:0] KIND_ASSIGN = 5'd19;
    localparam logic [4:0] KIND_PLUS   = 5'd20;
    localparam logic [4:0] KIND_PLUSEQ = 5'd21;
    localparam logic [4:0] KIND_MINUS  = 5'd22;
    localparam logic [4:0] KIND_MINEQ  = 5'd23;
    localparam logic [4:0] KIND_STAR   = 5'd24;
    localparam logic [4:0] KIND_STAREQ = 5'd25;
    localparam logic [4:0] KIND_DIV    = 5'd26;
    localparam logic [4:0] KIND_ERR    = 5'd27;
    localparam logic [4:0] KIND_NONE   = 5'd0;

    localparam logic [2:0] ERR_NONE       = 3'd0;
    localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
    localparam logic [2:0] ERR_BANG       = 3'd2;
    localparam logic [2:0] ERR_STR_NL     = 3'd3;
    localparam logic [2:0] ERR_STR_OPEN   = 3'd4;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_US     = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [15:0] LEN_MAX          = 16'hFFFF;
    localparam logic [15:0] START_LINE_RESET = 16'd2;

    logic [3:0]    mode_reg, mode_next;
    logic [PW-1:0] line_reg, line_next;
    logic [PW-1:0] col_reg, col_next;
    logic [PW-1:0] tline_reg, tline_next;
    logic [PW-1:0] tcol_reg, tcol_next;
    logic [15:0]   vlen_reg, vlen_next;

    logic                                    accept;
    logic                                    to_idle;
    logic [7:0]                              b;
    logic [4:0]                              pk;
    logic [4:0]                              run_kind;
    logic [stok_pkg::RES_COUNT_W-1:0]        nres;
    logic [stok_pkg::RES_COUNT_W-1:0]        lastpos;
    stok_pkg::result_t [stok_pkg::MAX_RESULTS-1:0] recs;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [4:0] punct_kind(input logic [7:0] c);
        logic [4:0] k;
        unique case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_SEMI:   k = KIND_SEMI;
            CH_COMMA:  k = KIND_COMMA;
            CH_COLON:  k = KIND_COLON;
            default:   k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] op_single(input logic [3:0] m);
        logic [4:0] k;
        unique case (m)
            MODE_EQ:    k = KIND_ASSIGN;
            MODE_LT:    k = KIND_LT;
            MODE_GT:    k = KIND_GT;
            MODE_PLUS:  k = KIND_PLUS;
            MODE_MINUS: k = KIND_MINUS;
            MODE_STAR:  k = KIND_STAR;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] op_double(input logic [3:0] m);
        logic [4:0] k;
        unique case (m)
            MODE_EQ:    k = KIND_EQEQ;
            MODE_LT:    k = KIND_LE;
            MODE_GT:    k = KIND_GE;
            MODE_BANG:  k = KIND_NE;
            MODE_PLUS:  k = KIND_PLUSEQ;
            MODE_MINUS: k = KIND_MINEQ;
            MODE_STAR:  k = KIND_STAREQ;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic logic [PW-1:0] pos_inc(input logic [PW-1:0] v);
        return (v == {PW{1'b1}}) ? v : v + PW'(1);
    endfunction

    function automatic logic [15:0] len_inc(input logic [15:0] v);
        return (v == LEN_MAX) ? v : v + 16'd1;
    endfunction

    function automatic logic [PW-1:0] pos_load(input logic [15:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        if (e > XW'({PW{1'b1}}))
        begin
            return {PW{1'b1}};
        end
        return PW'(e);
    endfunction

    function automatic logic [15:0] clip16(input logic [PW-1:0] v);
        logic [XW-1:0] e;
        e = XW'(v);
        if (e > XW'(LEN_MAX))
        begin
            return LEN_MAX;
        end
        return e[15:0];
    endfunction

    function automatic stok_pkg::result_t mk(
        input logic [4:0]    kind,
        input logic [PW-1:0] ln,
        input logic [PW-1:0] cl,
        input logic [7:0]    vb,
        input logic          vv,
        input logic          done,
        input logic [15:0]   len,
        input logic [2:0]    err
    );
        stok_pkg::result_t r;
        r.token_kind   = kind;
        r.token_line   = clip16(ln);
        r.token_column = clip16(cl);
        r.value_byte   = vb;
        r.value_valid  = vv;
        r.token_done   = done;
        r.token_length = len;
        r.error_code   = err;
        r.last         = 1'b0;
        return r;
    endfunction

    assign accept   = push && !full;
    assign b        = source.source_byte;
    assign run_kind = (mode_reg == MODE_IDENT) ? KIND_ID : KIND_NUM;
    assign pk       = punct_kind(b);

    always_comb
    begin
        mode_next  = mode_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        tline_next = tline_reg;
        tcol_next  = tcol_reg;
        vlen_next  = vlen_reg;
        recs       = '0;
        nres       = '0;
        to_idle    = 1'b0;
        lastpos    = '0;

        if (accept && mode_reg != MODE_HALT)
        begin
            if (source.byte_present)
            begin
                // pending token or lookahead first
                unique case (mode_reg)
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        if (is_digit(b) || (mode_reg == MODE_IDENT && is_alpha(b)))
                        begin
                            vlen_next = len_inc(vlen_next);
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(run_kind, tline_next,
                                tcol_next, b, 1'b1, 1'b0, 16'd0, ERR_NONE);
                            nres = nres + 3'd1;
                            col_next = pos_inc(col_next);
                        end
                        else
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(run_kind, tline_next,
                                tcol_next, 8'd0, 1'b0, 1'b1, vlen_next, ERR_NONE);
                            nres = nres + 3'd1;
                            to_idle = 1'b1;
                        end
                    end
                    MODE_STRING:
                    begin
                        if (b == CH_QUOTE)
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_STR, tline_next,
                                tcol_next, 8'd0, 1'b0, 1'b1, vlen_next, ERR_NONE);
                            nres = nres + 3'd1;
                            mode_next = MODE_IDLE;
                            col_next = pos_inc(col_next);
                        end
                        else if (b == CH_NL)
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_ERR, line_next,
                                col_next, 8'd0, 1'b0, 1'b1, 16'd0, ERR_STR_NL);
                            nres = nres + 3'd1;
                            mode_next = MODE_HALT;
                        end
                        else
                        begin
                            vlen_next = len_inc(vlen_next);
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_STR, tline_next,
                                tcol_next, b, 1'b1, 1'b0, 16'd0, ERR_NONE);
                            nres = nres + 3'd1;
                            col_next = pos_inc(col_next);
                        end
                    end
                    MODE_COMMENT:
                    begin
                        if (b != CH_NL)
                        begin
                            col_next = pos_inc(col_next);
                        end
                        else
                        begin
                            to_idle = 1'b1;
                        end
                    end
                    MODE_SLASH:
                    begin
                        if (b == CH_SLASH)
                        begin
                            mode_next = MODE_COMMENT;
                            col_next = pos_inc(col_next);
                        end
                        else
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_DIV, tline_next,
                                tcol_next, 8'd0, 1'b0, 1'b1, 16'd1, ERR_NONE);
                            nres = nres + 3'd1;
                            to_idle = 1'b1;
                        end
                    end
                    MODE_EQ, MODE_LT, MODE_GT, MODE_BANG, MODE_PLUS, MODE_MINUS, MODE_STAR:
                    begin
                        if (b == CH_EQ)
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(op_double(mode_reg),
                                tline_next, tcol_next, 8'd0, 1'b0, 1'b1, 16'd2, ERR_NONE);
                            nres = nres + 3'd1;
                            mode_next = MODE_IDLE;
                            col_next = pos_inc(col_next);
                        end
                        else if (mode_reg == MODE_BANG)
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_ERR, tline_next,
                                tcol_next, 8'd0, 1'b0, 1'b1, 16'd0, ERR_BANG);
                            nres = nres + 3'd1;
                            mode_next = MODE_HALT;
                        end
                        else
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(op_single(mode_reg),
                                tline_next, tcol_next, 8'd0, 1'b0, 1'b1, 16'd1, ERR_NONE);
                            nres = nres + 3'd1;
                            to_idle = 1'b1;
                        end
                    end
                    default:
                    begin
                        to_idle = 1'b1;
                    end
                endcase

                // byte starts fresh
                if (to_idle)
                begin
                    mode_next = MODE_IDLE;
                    priority if (b == CH_NL)
                    begin
                        line_next = pos_inc(line_next);
                        col_next  = PW'(1);
                    end
                    else if (b == CH_CR)
                    begin
                        col_next = PW'(1);
                    end
                    else if (b == CH_SPACE || b == CH_TAB)
                    begin
                        col_next = pos_inc(col_next);
                    end
                    else
                    begin
                        tline_next = line_next;
                        tcol_next  = col_next;
                        vlen_next  = 16'd0;
                        priority if (is_alpha(b) || is_digit(b))
                        begin
                            mode_next = is_alpha(b) ? MODE_IDENT : MODE_NUMBER;
                            vlen_next = 16'd1;
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(
                                is_alpha(b) ? KIND_ID : KIND_NUM, tline_next, tcol_next,
                                b, 1'b1, 1'b0, 16'd0, ERR_NONE);
                            nres = nres + 3'd1;
                        end
                        else if (b == CH_QUOTE) mode_next = MODE_STRING;
                        else if (b == CH_SLASH) mode_next = MODE_SLASH;
                        else if (b == CH_EQ)    mode_next = MODE_EQ;
                        else if (b == CH_LT)    mode_next = MODE_LT;
                        else if (b == CH_GT)    mode_next = MODE_GT;
                        else if (b == CH_BANG)  mode_next = MODE_BANG;
                        else if (b == CH_PLUS)  mode_next = MODE_PLUS;
                        else if (b == CH_MINUS) mode_next = MODE_MINUS;
                        else if (b == CH_STAR)  mode_next = MODE_STAR;
                        else if (pk == KIND_NONE)
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_ERR, line_next,
                                col_next, 8'd0, 1'b0, 1'b1, 16'd0, ERR_UNEXPECTED);
                            nres = nres + 3'd1;
                            mode_next = MODE_HALT;
                        end
                        else
                        begin
                            recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(pk, tline_next,
                                tcol_next, 8'd0, 1'b0, 1'b1, 16'd1, ERR_NONE);
                            nres = nres + 3'd1;
                        end
                        if (mode_next != MODE_HALT)
                        begin
                            col_next = pos_inc(col_next);
                        end
                    end
                end
            end

            // end of source closes what is pending
            if (source.end_of_source && mode_next != MODE_HALT)
            begin
                unique case (mode_next)
                    MODE_IDENT, MODE_NUMBER:
                    begin
                        recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(
                            (mode_next == MODE_IDENT) ? KIND_ID : KIND_NUM, tline_next,
                            tcol_next, 8'd0, 1'b0, 1'b1, vlen_next, ERR_NONE);
                        nres = nres + 3'd1;
                    end
                    MODE_STRING:
                    begin
                        recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_ERR, tline_next,
                            tcol_next, 8'd0, 1'b0, 1'b1, 16'd0, ERR_STR_OPEN);
                        nres = nres + 3'd1;
                        mode_next = MODE_HALT;
                    end
                    MODE_BANG:
                    begin
                        recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_ERR, tline_next,
                            tcol_next, 8'd0, 1'b0, 1'b1, 16'd0, ERR_BANG);
                        nres = nres + 3'd1;
                        mode_next = MODE_HALT;
                    end
                    MODE_SLASH:
                    begin
                        recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_DIV, tline_next,
                            tcol_next, 8'd0, 1'b0, 1'b1, 16'd1, ERR_NONE);
                        nres = nres + 3'd1;
                    end
                    MODE_EQ, MODE_LT, MODE_GT, MODE_PLUS, MODE_MINUS, MODE_STAR:
                    begin
                        recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(op_single(mode_next),
                            tline_next, tcol_next, 8'd0, 1'b0, 1'b1, 16'd1, ERR_NONE);
                        nres = nres + 3'd1;
                    end
                    default:
                    begin
                    end
                endcase
                if (mode_next != MODE_HALT)
                begin
                    recs[nres[stok_pkg::RES_IDX_W-1:0]] = mk(KIND_EOF, line_next, col_next,
                        8'd0, 1'b0, 1'b1, 16'd0, ERR_NONE);
                    nres = nres + 3'd1;
                    mode_next = MODE_IDLE;
                end
            end

            if (nres != '0)
            begin
                lastpos = nres - 3'd1;
                recs[lastpos[stok_pkg::RES_IDX_W-1:0]].last = 1'b1;
            end
        end

        if (cfg_valid)
        begin
            line_next = pos_load(cfg_data);
        end
    end

    assign wr_en        = accept && (nres != '0);
    assign bundle.count = nres;
    assign bundle.recs  = recs;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            line_reg  <= pos_load(START_LINE_RESET);
            col_reg   <= PW'(1);
            tline_reg <= '0;
            tcol_reg  <= '0;
            vlen_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            tline_reg <= tline_next;
            tcol_reg  <= tcol_next;
            vlen_reg  <= vlen_next;
        end
    end

    `STOK_ASSERT_NEXT(halt_sticky, mode_reg == MODE_HALT && !cfg_valid, mode_reg == MODE_HALT, "lexer left halt without reset")
    `STOK_ASSERT(bundle_count_ok, !wr_en || (bundle.count != '0 && bundle.count <= 3'd4), "bad bundle count")

endmodule

// ===== design/stok_queue.sv =====
// short bundle queue between lexer front and result back
`include "source_tokenizer_assert.svh"

module stok_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  stok_pkg::bundle_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output stok_pkg::bundle_t rd_data,
    output logic              nonempty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    stok_pkg::bundle_t mem_reg [DEPTH];
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [CW-1:0] count_reg, count_next;

    function automatic logic [AW-1:0] ptr_adv(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rd_data  = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wr_en ? ptr_adv(wptr_reg) : wptr_reg;
        rptr_next  = rd_en ? ptr_adv(rptr_reg) : rptr_reg;
        count_next = count_reg;
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    `STOK_ASSERT(no_overrun, !(wr_en && full) && !(rd_en && !nonempty), "queue overrun or underrun")

endmodule

// ===== design/stok_back.sv =====
// result back: hands out the records of each bundle one transfer at a time
`include "source_tokenizer_assert.svh"

module stok_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              nonempty,
    input  stok_pkg::bundle_t rd_data,
    output logic              rd_en,
    input  logic              pop,
    output logic              empty,
    output stok_pkg::result_t token
);

    stok_pkg::bundle_t                  cur_reg;
    logic                               valid_reg, valid_next;
    logic [stok_pkg::RES_IDX_W-1:0]     idx_reg, idx_next;
    logic                               at_end;
    logic                               taken;

    assign empty  = !valid_reg;
    assign token  = cur_reg.recs[idx_reg];
    assign taken  = pop && valid_reg;
    assign at_end = ({1'b0, idx_reg} == cur_reg.count - 3'd1);
    assign rd_en  = nonempty && (!valid_reg || (taken && at_end));

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (rd_en)
        begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (taken && at_end)
        begin
            valid_next = 1'b0;
            idx_next   = '0;
        end
        else if (taken)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            cur_reg <= rd_data;
        end
    end

    `STOK_ASSERT(idx_in_bundle, !valid_reg || ({1'b0, idx_reg} < cur_reg.count), "record index past bundle")
    `STOK_ASSERT_NEXT(idx_steps, taken && !at_end, valid_reg && idx_reg == $past(idx_reg) + 2'd1, "record index did not step")

endmodule
